// ===== design/vbaf_pkg.sv =====
// Shared types, constants and mode decode for the view box aspect fit transform.
package vbaf_pkg;

    localparam int SIZE_W    = 31;           // unsigned size and scale fields
    localparam int EDGE_W    = 32;           // signed edge and shift fields
    localparam int PROD_W    = 2 * SIZE_W;   // size by size product
    localparam int DIV_NW    = 64;           // divider dividend width
    localparam int DIV_DW    = SIZE_W + 1;   // divider divisor width
    localparam int DIV_LAT   = SIZE_W + 1;   // divider depth, length of the side delay line
    localparam int CFG_IDX_W = 4;
    localparam int CFG_DAT_W = 4;

    localparam logic [CFG_IDX_W-1:0] REG_ALIGN = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_FIT   = CFG_IDX_W'(1);

    localparam logic [3:0] ALIGN_RESET = 4'd5;

    typedef enum logic [1:0]
    {
        K_MIN = 2'd0,
        K_MID = 2'd1,
        K_MAX = 2'd2
    } align_k_t;

    typedef struct packed
    {
        logic     none;
        align_k_t kx;
        align_k_t ky;
    } mode_t;

    typedef struct packed
    {
        logic signed [EDGE_W-1:0] bx;
        logic signed [EDGE_W-1:0] by;
        logic [SIZE_W-1:0]        bw;
        logic [SIZE_W-1:0]        bh;
        logic [SIZE_W-1:0]        pw;
        logic [SIZE_W-1:0]        ph;
        mode_t                    mode;
        logic                     fit;
        logic                     invalid;
    } item_t;

    typedef struct packed
    {
        item_t item;
        logic  pick_x;
    } side_t;

    typedef struct packed
    {
        logic [SIZE_W-1:0] scale_x;
        logic [SIZE_W-1:0] scale_y;
        logic [EDGE_W-1:0] shift_x;
        logic [EDGE_W-1:0] shift_y;
        logic [EDGE_W-1:0] clip_x;
        logic [EDGE_W-1:0] clip_y;
        logic [SIZE_W-1:0] clip_w;
        logic [SIZE_W-1:0] clip_h;
        logic              invalid;
        logic              none;
    } res_t;

    // alignment code to per-axis placement; unused codes act as xMidYMid
    function automatic mode_t decode_mode(logic [3:0] a);
        mode_t m;
        m.none = 1'b0;
        m.kx   = K_MID;
        m.ky   = K_MID;
        unique case (a)
            4'd0:
            begin
                m.none = 1'b1;
                m.kx   = K_MIN;
                m.ky   = K_MIN;
            end
            4'd1: begin m.kx = K_MIN; m.ky = K_MIN; end
            4'd2: begin m.kx = K_MID; m.ky = K_MIN; end
            4'd3: begin m.kx = K_MAX; m.ky = K_MIN; end
            4'd4: begin m.kx = K_MIN; m.ky = K_MID; end
            4'd5: begin m.kx = K_MID; m.ky = K_MID; end
            4'd6: begin m.kx = K_MAX; m.ky = K_MID; end
            4'd7: begin m.kx = K_MIN; m.ky = K_MAX; end
            4'd8: begin m.kx = K_MID; m.ky = K_MAX; end
            4'd9: begin m.kx = K_MAX; m.ky = K_MAX; end
            default: begin m.kx = K_MID; m.ky = K_MID; end
        endcase
        return m;
    endfunction

endpackage

// ===== design/vbaf_if.sv =====
// Channel interfaces: input beats, result beats and configuration writes.
interface vbaf_in_if import vbaf_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [EDGE_W-1:0] box_x;
    logic signed [EDGE_W-1:0] box_y;
    logic [SIZE_W-1:0]        box_w;
    logic [SIZE_W-1:0]        box_h;
    logic [SIZE_W-1:0]        port_w;
    logic [SIZE_W-1:0]        port_h;

    modport source (output valid, box_x, box_y, box_w, box_h, port_w, port_h, input ready);
    modport sink   (input valid, box_x, box_y, box_w, box_h, port_w, port_h, output ready);
endinterface

interface vbaf_out_if import vbaf_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [SIZE_W-1:0]        scale_x;
    logic [SIZE_W-1:0]        scale_y;
    logic signed [EDGE_W-1:0] shift_x;
    logic signed [EDGE_W-1:0] shift_y;
    logic signed [EDGE_W-1:0] clip_x;
    logic signed [EDGE_W-1:0] clip_y;
    logic [SIZE_W-1:0]        clip_w;
    logic [SIZE_W-1:0]        clip_h;
    logic                     invalid;

    modport source (output valid, scale_x, scale_y, shift_x, shift_y, clip_x, clip_y,
                    clip_w, clip_h, invalid, input ready);
    modport sink   (input valid, scale_x, scale_y, shift_x, shift_y, clip_x, clip_y,
                    clip_w, clip_h, invalid, output ready);
endinterface

interface vbaf_cfg_if import vbaf_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/vbaf_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, saturating quotient.
module vbaf_div import vbaf_pkg::*;
(
    input  logic              clk,
    input  logic              en,
    input  logic [DIV_NW-1:0] num,
    input  logic [DIV_DW-1:0] den,
    output logic [SIZE_W-1:0] quo
);

    logic [DIV_NW-1:0] rem_reg [SIZE_W+1];
    logic [DIV_DW-1:0] den_reg [SIZE_W+1];
    logic [SIZE_W-1:0] q_reg   [SIZE_W+1];
    logic              sat_reg [SIZE_W+1];

    // first stage: quotient too large for the field
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= num;
            den_reg[0] <= den;
            q_reg[0]   <= '0;
            sat_reg[0] <= (num >= (DIV_NW'(den) << SIZE_W));
        end
    end

    // one compare and subtract per stage, most significant bit first
    for (genvar j = 1; j <= SIZE_W; j++)
    begin : g_stage
        localparam int B = SIZE_W - j;
        logic [DIV_NW-1:0] dsh;
        logic              ge;
        assign dsh = DIV_NW'(den_reg[j-1]) << B;
        assign ge  = (rem_reg[j-1] >= dsh);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[j] <= ge ? (rem_reg[j-1] - dsh) : rem_reg[j-1];
                den_reg[j] <= den_reg[j-1];
                q_reg[j]   <= q_reg[j-1] | (ge ? (SIZE_W'(1) << B) : '0);
                sat_reg[j] <= sat_reg[j-1];
            end
        end
    end

    assign quo = sat_reg[SIZE_W] ? '1 : q_reg[SIZE_W];

endmodule

// ===== design/vbaf_back.sv =====
// Back end: scale products, translation and visible edge sums, rounding.
module vbaf_back import vbaf_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  side_t             side,
    input  logic [SIZE_W-1:0] sx,
    input  logic [SIZE_W-1:0] sy,
    input  logic [SIZE_W-1:0] cross_sz,
    output logic              out_valid,
    output res_t              res
);

    localparam int AW = 66;
    localparam int CW = EDGE_W + 2;

    function automatic logic [EDGE_W-1:0] sat32(logic signed [AW-1:0] x);
        if (x > AW'(64'sd2147483647))
            return {1'b0, {(EDGE_W-1){1'b1}}};
        if (x < -AW'(64'sd2147483648))
            return {1'b1, {(EDGE_W-1){1'b0}}};
        return x[EDGE_W-1:0];
    endfunction

    // stage 1 registers
    logic                     v1_reg;
    item_t                    it1_reg;
    logic [SIZE_W-1:0]        sax_reg, say_reg, cw1_reg, ch1_reg;
    logic signed [PROD_W:0]   bxs_reg, bys_reg;
    logic [PROD_W-1:0]        bws_reg, bhs_reg;
    // stage 2 registers
    logic                     v2_reg;
    item_t                    it2_reg;
    logic [SIZE_W-1:0]        sax2_reg, say2_reg, cw2_reg, ch2_reg;
    logic signed [AW-1:0]     vx_reg, vy_reg;
    logic signed [CW-1:0]     cx_reg, cy_reg;
    // output register
    logic                     v3_reg;
    res_t                     res_reg;

    logic [SIZE_W-1:0] s_u, sax_n, say_n, cw_n, ch_n;

    // stage 1: pick the scale, form the four products
    always_comb
    begin
        s_u   = side.pick_x ? sx : sy;
        sax_n = side.item.mode.none ? sx : s_u;
        say_n = side.item.mode.none ? sy : s_u;
        if (side.item.mode.none)
        begin
            cw_n = side.item.bw;
            ch_n = side.item.bh;
        end
        else if (side.pick_x)
        begin
            cw_n = side.item.bw;
            ch_n = cross_sz;
        end
        else
        begin
            cw_n = cross_sz;
            ch_n = side.item.bh;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            it1_reg <= side.item;
            sax_reg <= sax_n;
            say_reg <= say_n;
            cw1_reg <= cw_n;
            ch1_reg <= ch_n;
            bxs_reg <= (PROD_W+1)'(side.item.bx) * $signed({1'b0, sax_n});
            bys_reg <= (PROD_W+1)'(side.item.by) * $signed({1'b0, say_n});
            bws_reg <= PROD_W'(side.item.bw) * PROD_W'(sax_n);
            bhs_reg <= PROD_W'(side.item.bh) * PROD_W'(say_n);
        end
    end

    // stage 2: exact translation with FRAC_BITS fraction bits, visible edges
    function automatic logic signed [AW-1:0] offs(logic signed [PROD_W:0] bs,
                                                  logic [PROD_W-1:0] zs,
                                                  logic [SIZE_W-1:0] p, align_k_t k);
        logic signed [AW-1:0] t;
        logic signed [AW-1:0] v;
        t = (AW'(p) << FRAC_BITS) - $signed(AW'(zs));
        v = -AW'(bs);
        unique case (k)
            K_MAX:   v = v + t;
            K_MID:   v = v + (t >>> 1);
            default: v = v;
        endcase
        return v;
    endfunction

    function automatic logic signed [CW-1:0] edge_of(logic signed [EDGE_W-1:0] b,
                                                     logic [SIZE_W-1:0] bsz,
                                                     logic [SIZE_W-1:0] vsz, align_k_t k);
        logic signed [CW-1:0] d;
        logic signed [CW-1:0] adj;
        d = $signed(CW'(vsz)) - $signed(CW'(bsz));
        unique case (k)
            K_MAX:   adj = d;
            K_MID:   adj = (d + CW'(1)) >>> 1;
            default: adj = '0;
        endcase
        return CW'(b) - adj;
    endfunction

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            it2_reg  <= it1_reg;
            sax2_reg <= sax_reg;
            say2_reg <= say_reg;
            cw2_reg  <= cw1_reg;
            ch2_reg  <= ch1_reg;
            vx_reg   <= offs(bxs_reg, bws_reg, it1_reg.pw, it1_reg.mode.kx);
            vy_reg   <= offs(bys_reg, bhs_reg, it1_reg.ph, it1_reg.mode.ky);
            cx_reg   <= edge_of(it1_reg.bx, it1_reg.bw, cw1_reg, it1_reg.mode.kx);
            cy_reg   <= edge_of(it1_reg.by, it1_reg.bh, ch1_reg, it1_reg.mode.ky);
        end
    end

    // stage 3: round to nearest, saturate, zero on a bad size
    res_t res_n;
    logic signed [AW-1:0] half;
    assign half = AW'(1) << (FRAC_BITS - 1);

    always_comb
    begin
        res_n.scale_x = sax2_reg;
        res_n.scale_y = say2_reg;
        res_n.shift_x = sat32((vx_reg + half) >>> FRAC_BITS);
        res_n.shift_y = sat32((vy_reg + half) >>> FRAC_BITS);
        res_n.clip_x  = sat32(AW'(cx_reg));
        res_n.clip_y  = sat32(AW'(cy_reg));
        res_n.clip_w  = cw2_reg;
        res_n.clip_h  = ch2_reg;
        res_n.invalid = it2_reg.invalid;
        res_n.none    = it2_reg.mode.none;
        if (it2_reg.invalid)
        begin
            res_n         = '0;
            res_n.invalid = 1'b1;
            res_n.none    = it2_reg.mode.none;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg <= res_n;
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    assign out_valid = v3_reg;
    assign res       = res_reg;

endmodule

// ===== design/viewbox_aspect_fit_transform.sv =====
// Top level of the view box aspect fit transform pipeline.
// Usage: one input beat on in_ch carries a view box (x, y, w, h) and a
// viewport size; one result beat on out_ch carries the fit scales, shifts,
// the visible rectangle in view box coordinates and the invalid flag.
// The cfg channel writes align_mode (index 0) and fit_mode (index 1); it is
// always ready and takes effect on beats accepted afterwards.
// Pipeline from input beat to result beat: input register, product stage,
// 32-stage divider and three back-end stages, the last being the output
// register. Throughput: one beat per cycle while the receiver takes results,
// set by the pipelined divider taking a new dividend every enabled cycle.
// The whole pipeline moves on one enable: it advances when the output
// register is empty or being taken, so when the receiver stalls every
// stage holds and in_ch.ready drops; nothing is lost or repeated.
// Reset clears every valid bit and loads align_mode 5, fit_mode 0.
module viewbox_aspect_fit_transform import vbaf_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic     clk,
    input  logic     rst_n,
    vbaf_in_if.sink  in_ch,
    vbaf_out_if.source out_ch,
    vbaf_cfg_if.sink cfg
);

    logic       en;
    logic [3:0] align_reg;
    logic       fit_reg;

    // configuration registers
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            align_reg <= ALIGN_RESET;
            fit_reg   <= 1'b0;
        end
        else if (cfg.valid)
        begin
            if (cfg.index == REG_ALIGN)
            begin
                align_reg <= cfg.data[3:0];
            end
            else if (cfg.index == REG_FIT)
            begin
                fit_reg <= cfg.data[0];
            end
        end
    end

    logic back_valid;
    res_t back_res;

    assign en          = !back_valid || out_ch.ready;
    assign in_ch.ready = en;

    // input register
    item_t p1_reg;
    logic  p1v_reg;
    item_t p1_next;

    always_comb
    begin
        p1_next.bx      = in_ch.box_x;
        p1_next.by      = in_ch.box_y;
        p1_next.bw      = in_ch.box_w;
        p1_next.bh      = in_ch.box_h;
        p1_next.pw      = in_ch.port_w;
        p1_next.ph      = in_ch.port_h;
        p1_next.mode    = decode_mode(align_reg);
        p1_next.fit     = fit_reg;
        p1_next.invalid = (in_ch.box_w == '0) || (in_ch.box_h == '0) ||
                          (in_ch.port_w == '0) || (in_ch.port_h == '0);
    end

    // product stage for the axis ratio compare
    item_t             p2_reg;
    logic              p2v_reg;
    logic [PROD_W-1:0] xr_reg, yr_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_reg <= p1_next;
            p2_reg <= p1_reg;
            xr_reg <= PROD_W'(p1_reg.pw) * PROD_W'(p1_reg.bh);
            yr_reg <= PROD_W'(p1_reg.ph) * PROD_W'(p1_reg.bw);
        end
    end

    // axis choice and divider operands, rounding folded into num and den
    logic              pick_x;
    logic [DIV_NW-1:0] nx, ny, nc;
    logic [DIV_DW-1:0] dx, dy, dc;

    always_comb
    begin
        pick_x = p2_reg.fit ? (xr_reg >= yr_reg) : (xr_reg <= yr_reg);
        nx = (DIV_NW'(p2_reg.pw) << (FRAC_BITS + 1)) + DIV_NW'(p2_reg.bw);
        ny = (DIV_NW'(p2_reg.ph) << (FRAC_BITS + 1)) + DIV_NW'(p2_reg.bh);
        dx = {p2_reg.bw, 1'b0};
        dy = {p2_reg.bh, 1'b0};
        if (pick_x)
        begin
            nc = (DIV_NW'(yr_reg) << 1) + DIV_NW'(p2_reg.pw);
            dc = {p2_reg.pw, 1'b0};
        end
        else
        begin
            nc = (DIV_NW'(xr_reg) << 1) + DIV_NW'(p2_reg.ph);
            dc = {p2_reg.ph, 1'b0};
        end
    end

    logic [SIZE_W-1:0] sx, sy, cross_sz;

    vbaf_div u_div_x (.clk(clk), .en(en), .num(nx), .den(dx), .quo(sx));
    vbaf_div u_div_y (.clk(clk), .en(en), .num(ny), .den(dy), .quo(sy));
    vbaf_div u_div_c (.clk(clk), .en(en), .num(nc), .den(dc), .quo(cross_sz));

    // side data delay line alongside the dividers
    side_t side_reg [DIV_LAT];
    logic  sv_reg   [DIV_LAT];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= '{item: p2_reg, pick_x: pick_x};
            for (int i = 1; i < DIV_LAT; i++)
            begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1v_reg <= 1'b0;
            p2v_reg <= 1'b0;
            for (int i = 0; i < DIV_LAT; i++)
            begin
                sv_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            p1v_reg   <= in_ch.valid;
            p2v_reg   <= p1v_reg;
            sv_reg[0] <= p2v_reg;
            for (int i = 1; i < DIV_LAT; i++)
            begin
                sv_reg[i] <= sv_reg[i-1];
            end
        end
    end

    vbaf_back #(.FRAC_BITS(FRAC_BITS)) u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sv_reg[DIV_LAT-1]),
        .side      (side_reg[DIV_LAT-1]),
        .sx        (sx),
        .sy        (sy),
        .cross_sz  (cross_sz),
        .out_valid (back_valid),
        .res       (back_res)
    );

    assign out_ch.valid   = back_valid;
    assign out_ch.scale_x = back_res.scale_x;
    assign out_ch.scale_y = back_res.scale_y;
    assign out_ch.shift_x = back_res.shift_x;
    assign out_ch.shift_y = back_res.shift_y;
    assign out_ch.clip_x  = back_res.clip_x;
    assign out_ch.clip_y  = back_res.clip_y;
    assign out_ch.clip_w  = back_res.clip_w;
    assign out_ch.clip_h  = back_res.clip_h;
    assign out_ch.invalid = back_res.invalid;

    // a bad size gives zero scale, shift and clip fields; checked on scale_x, shift_x and clip_w
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        back_valid && back_res.invalid |->
            back_res.scale_x == '0 && back_res.shift_x == '0 && back_res.clip_w == '0)
        else $error("invalid result with non-zero fields");

    // uniform alignment gives one scale for both axes
    a_uniform: assert property (@(posedge clk) disable iff (!rst_n)
        back_valid && !back_res.invalid && !back_res.none |->
            back_res.scale_x == back_res.scale_y)
        else $error("uniform fit with differing scales");

    // a stalled result is never overwritten by the pipeline
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        back_valid && !out_ch.ready |=> back_valid && $stable(back_res))
        else $error("stalled result changed");

endmodule

// ===== test/tb_vbaf_if.sv =====
// Testbench channel interfaces are those of the design; this file holds the checker-side result record.
package tb_vbaf_pkg;
    import vbaf_pkg::*;

    // one expected or observed result beat
    typedef struct packed
    {
        logic [SIZE_W-1:0] scale_x;
        logic [SIZE_W-1:0] scale_y;
        logic [EDGE_W-1:0] shift_x;
        logic [EDGE_W-1:0] shift_y;
        logic [EDGE_W-1:0] clip_x;
        logic [EDGE_W-1:0] clip_y;
        logic [SIZE_W-1:0] clip_w;
        logic [SIZE_W-1:0] clip_h;
        logic              invalid;
    } fit_t;
endpackage

// ===== test/tb_top.sv =====
// Self-checking testbench for the view box aspect fit transform.
module tb_top;
    import vbaf_pkg::*;
    import tb_vbaf_pkg::*;

    localparam int FB = 16;
    localparam int LATENCY = 37;
    localparam int STALL_LIMIT = 20000;
    localparam logic [30:0] MAX31 = 31'h7FFFFFFF;

    logic clk;
    logic rst_n;

    vbaf_in_if  in_ch();
    vbaf_out_if out_ch();
    vbaf_cfg_if cfg();

    viewbox_aspect_fit_transform #(.FRAC_BITS(FB)) u_top
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg    (cfg)
    );

    // predictor copy of the registers
    logic [3:0] align_reg;
    logic       fit_reg;

    fit_t expected_fits[$];
    int   errors;
    int   beats_sent;
    int   beats_checked;
    int   idle_cycles;
    bit   sink_stalls;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // rounded unsigned divide, ties up
    function automatic longint unsigned rdiv(longint unsigned n, longint unsigned d);
        if (d == 0)
            return 0;
        return (2 * n + d) / (2 * d);
    endfunction

    function automatic longint unsigned clamp31(longint unsigned v);
        return (v > 64'h7FFFFFFF) ? 64'h7FFFFFFF : v;
    endfunction

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    // arithmetic shift is a floor divide by a power of two
    function automatic longint round_q(longint v);
        return (v + (64'sd1 <<< (FB - 1))) >>> FB;
    endfunction

    function automatic longint fit_shift(longint b, longint unsigned bsize,
                                         longint unsigned port, longint s, align_k_t k);
        longint v;
        longint t;
        v = -(b * s);
        t = longint'(port << FB) - longint'(bsize) * s;
        if (k == K_MAX)
            v += t;
        else if (k == K_MID)
            v += t >>> 1;
        return clamp32(round_q(v));
    endfunction

    function automatic longint fit_edge(longint b, longint unsigned bsize,
                                        longint unsigned vsize, align_k_t k);
        longint d;
        longint adj;
        d = longint'(vsize) - longint'(bsize);
        adj = 0;
        if (k == K_MAX)
            adj = d;
        else if (k == K_MID)
            adj = (d + 1) >>> 1;
        return clamp32(b - adj);
    endfunction

    // expected result for one view box under the current registers
    function automatic fit_t predict_fit(logic signed [31:0] bx_i, logic signed [31:0] by_i,
                                         logic [30:0] bw_i, logic [30:0] bh_i,
                                         logic [30:0] pw_i, logic [30:0] ph_i);
        fit_t r;
        longint bx, by, tx, ty, cx, cy;
        longint unsigned bw, bh, pw, ph, sx, sy, cw, ch, xr, yr, s;
        align_k_t kx, ky;
        bit pick_x;
        int m;
        r = '0;
        bx = bx_i; by = by_i; bw = bw_i; bh = bh_i; pw = pw_i; ph = ph_i;
        if (bw == 0 || bh == 0 || pw == 0 || ph == 0)
        begin
            r.invalid = 1'b1;
            return r;
        end
        sx = clamp31(rdiv(pw << FB, bw));
        sy = clamp31(rdiv(ph << FB, bh));
        m = (align_reg > 9) ? 5 : align_reg;
        if (m == 0)
        begin
            tx = clamp32(round_q(-(bx * longint'(sx))));
            ty = clamp32(round_q(-(by * longint'(sy))));
            cx = bx; cy = by; cw = bw; ch = bh;
        end
        else
        begin
            kx = align_k_t'((m - 1) % 3);
            ky = align_k_t'((m - 1) / 3);
            xr = pw * bh;
            yr = ph * bw;
            pick_x = fit_reg ? (xr >= yr) : (xr <= yr);
            if (pick_x)
            begin
                s = sx; cw = bw; ch = clamp31(rdiv(ph * bw, pw));
            end
            else
            begin
                s = sy; ch = bh; cw = clamp31(rdiv(pw * bh, ph));
            end
            sx = s; sy = s;
            tx = fit_shift(bx, bw, pw, longint'(s), kx);
            ty = fit_shift(by, bh, ph, longint'(s), ky);
            cx = fit_edge(bx, bw, cw, kx);
            cy = fit_edge(by, bh, ch, ky);
        end
        r.scale_x = sx[30:0];
        r.scale_y = sy[30:0];
        r.shift_x = tx[31:0];
        r.shift_y = ty[31:0];
        r.clip_x  = cx[31:0];
        r.clip_y  = cy[31:0];
        r.clip_w  = cw[30:0];
        r.clip_h  = ch[30:0];
        return r;
    endfunction

    // send one view box beat after a random gap; valid stays up for a
    // following beat with no gap and is dropped by the gap or the drain
    task automatic send_box(logic signed [31:0] bx, logic signed [31:0] by, logic [30:0] bw,
                            logic [30:0] bh, logic [30:0] pw, logic [30:0] ph);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
        if (gap != 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.valid  <= 1'b1;
        in_ch.box_x  <= bx;
        in_ch.box_y  <= by;
        in_ch.box_w  <= bw;
        in_ch.box_h  <= bh;
        in_ch.port_w <= pw;
        in_ch.port_h <= ph;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        expected_fits.insert(expected_fits.size(), predict_fit(bx, by, bw, bh, pw, ph));
        beats_sent++;
        @(negedge clk);
    endtask

    // register write while the pipeline is empty
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] value);
        wait_drained();
        @(negedge clk);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= value;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        if (idx == REG_ALIGN)
            align_reg = value;
        else if (idx == REG_FIT)
            fit_reg = value[0];
        @(negedge clk);
        cfg.valid <= 1'b0;
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (expected_fits.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // random size: mostly moderate, sometimes extreme
    function automatic logic [30:0] rand_size();
        case ($urandom_range(0, 9))
            0: return 31'($urandom_range(1, 16));
            1: return MAX31 - 31'($urandom_range(0, 3));
            2: return 31'($urandom);
            3: return 31'($urandom_range(1, 255)) << 16;
            default: return 31'($urandom_range(1, 32'h00FFFFFF));
        endcase
    endfunction

    function automatic logic [31:0] rand_edge();
        case ($urandom_range(0, 5))
            0: return 32'h80000000;
            1: return 32'h7FFFFFFF;
            2: return $urandom;
            default: return 32'($signed($urandom_range(0, 32'h01FFFFFF)) - 32'sh00FFFFFF);
        endcase
    endfunction

    task automatic send_random(int count);
        logic [30:0] bw, bh, pw, ph;
        repeat (count)
        begin
            bw = rand_size(); bh = rand_size(); pw = rand_size(); ph = rand_size();
            // occasional zero size to hit the invalid path
            if ($urandom_range(0, 29) == 0)
                case ($urandom_range(0, 3))
                    0: bw = '0;
                    1: bh = '0;
                    2: pw = '0;
                    default: ph = '0;
                endcase
            // occasional equal aspect ratio to hit the tie between axes
            if ($urandom_range(0, 9) == 0)
            begin
                pw = bw; ph = bh;
            end
            send_box(rand_edge(), rand_edge(), bw, bh, pw, ph);
        end
    endtask

    task automatic test_directed();
        send_box(32'sh00010000, 32'sh00020000, 31'h00640000, 31'h00320000,
                 31'h00C80000, 31'h00C80000);
        send_box(32'h80000000, 32'h7FFFFFFF, MAX31, MAX31, MAX31, MAX31);
        send_box(32'h7FFFFFFF, 32'h80000000, 31'd1, 31'd1, MAX31, MAX31);
        send_box(32'hFFFFFFFF, 32'h00000000, 31'd1, MAX31, MAX31, 31'd1);
        send_box(32'h0, 32'h0, 31'd0, 31'd5, 31'd5, 31'd5);
        send_box(32'h0, 32'h0, 31'd5, 31'd0, 31'd5, 31'd5);
        send_box(32'h0, 32'h0, 31'd5, 31'd5, 31'd0, 31'd5);
        send_box(32'h0, 32'h0, 31'd5, 31'd5, 31'd5, 31'd0);
        send_box(32'sh00050000, -32'sh00030000, 31'h00030000, 31'h00070000,
                 31'h00070000, 31'h00030000);
        send_box(32'h0, 32'h0, 31'd3, 31'd3, 31'd7, 31'd7);
    endtask

    // every alignment code, including the unused ones, under both fit modes
    task automatic test_alignments();
        for (int f = 0; f < 2; f++)
        begin
            write_reg(REG_FIT, CFG_DAT_W'(f));
            for (int a = 0; a < 16; a++)
            begin
                write_reg(REG_ALIGN, CFG_DAT_W'(a));
                send_random(8);
            end
        end
    endtask

    task automatic test_random();
        for (int p = 0; p < 12; p++)
        begin
            write_reg(REG_ALIGN, ($urandom_range(0, 3) == 0) ? 4'd0 : 4'($urandom_range(0, 15)));
            write_reg(REG_FIT, CFG_DAT_W'($urandom_range(0, 1)));
            // one phase runs with the receiver always ready
            sink_stalls = (p != 5);
            send_random(50);
        end
        sink_stalls = 1'b1;
        // unknown register index is ignored
        write_reg(4'd7, 4'd0);
        write_reg(4'd15, 4'd1);
        send_random(10);
    endtask

    // result checker
    always @(posedge clk)
    begin
        fit_t got;
        fit_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got.scale_x = out_ch.scale_x; got.scale_y = out_ch.scale_y;
            got.shift_x = out_ch.shift_x; got.shift_y = out_ch.shift_y;
            got.clip_x  = out_ch.clip_x;  got.clip_y  = out_ch.clip_y;
            got.clip_w  = out_ch.clip_w;  got.clip_h  = out_ch.clip_h;
            got.invalid = out_ch.invalid;
            if (expected_fits.size() == 0)
            begin
                $display("%0t unexpected result beat %h", $time, got);
                errors++;
            end
            else
            begin
                want = expected_fits.pop_front();
                beats_checked++;
                if (got.scale_x !== want.scale_x)
                begin $display("%0t scale_x exp %h got %h", $time, want.scale_x, got.scale_x); errors++; end
                if (got.scale_y !== want.scale_y)
                begin $display("%0t scale_y exp %h got %h", $time, want.scale_y, got.scale_y); errors++; end
                if (got.shift_x !== want.shift_x)
                begin $display("%0t shift_x exp %h got %h", $time, want.shift_x, got.shift_x); errors++; end
                if (got.shift_y !== want.shift_y)
                begin $display("%0t shift_y exp %h got %h", $time, want.shift_y, got.shift_y); errors++; end
                if (got.clip_x !== want.clip_x)
                begin $display("%0t clip_x exp %h got %h", $time, want.clip_x, got.clip_x); errors++; end
                if (got.clip_y !== want.clip_y)
                begin $display("%0t clip_y exp %h got %h", $time, want.clip_y, got.clip_y); errors++; end
                if (got.clip_w !== want.clip_w)
                begin $display("%0t clip_w exp %h got %h", $time, want.clip_w, got.clip_w); errors++; end
                if (got.clip_h !== want.clip_h)
                begin $display("%0t clip_h exp %h got %h", $time, want.clip_h, got.clip_h); errors++; end
                if (got.invalid !== want.invalid)
                begin $display("%0t invalid exp %b got %b", $time, want.invalid, got.invalid); errors++; end
            end
        end
    end

    // receiver stalls: a random hold-off before each beat is taken
    initial
    begin
        int hold;
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            hold = sink_stalls ? $urandom_range(0, 8) : 0;
            if (hold != 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (hold) @(negedge clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge clk);
            while (!out_ch.valid)
                @(posedge clk);
        end
    end

    // watchdog on cycles with no beat accepted anywhere
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("watchdog: %0d results still outstanding", expected_fits.size());
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        errors = 0; beats_sent = 0; beats_checked = 0; idle_cycles = 0;
        sink_stalls = 1'b1;
        align_reg = ALIGN_RESET;
        fit_reg = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.box_x = '0; in_ch.box_y = '0; in_ch.box_w = '0;
        in_ch.box_h = '0; in_ch.port_w = '0; in_ch.port_h = '0;
        cfg.valid = 1'b0; cfg.index = '0; cfg.data = '0;
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        test_alignments();
        test_random();
        wait_drained();
        repeat (LATENCY + 8) @(posedge clk);
        $display("sent %0d view boxes over all 16 alignment codes and both fit modes,", beats_sent);
        $display("checked %0d results, %0d mismatches", beats_checked, errors);
        if (errors == 0 && expected_fits.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
